// ----- src/scs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry canonical subset check: shared definitions
// Sizes, step numbers and types used by the core and its submodules.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int Positions = 24;
   localparam int IdxW      = $clog2(Positions);
   localparam int SizeW     = 5;
   localparam int Rotations = 3;

   // Crossbar passes per check: one reflection, then two chains of
   // rotations, each rotation being a transposition and a reflection.
   localparam int ChainPasses = 2 * Rotations;
   localparam int LastStep    = 2 * ChainPasses;
   localparam int StepW       = $clog2(LastStep + 1);

   localparam logic OpLoad  = 1'b0;
   localparam logic OpCheck = 1'b1;

   localparam logic [2:0] RegActiveSize = 3'd0;

   typedef logic [Positions-1:0]           bitmap_type;
   typedef logic [Positions-1:0][IdxW-1:0] perm_table_type;

   typedef struct packed {
      logic       exhausted;
      bitmap_type next_bitmap;
   } succ_result_type;

endpackage

// ----- src/scs_permute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation crossbar
// Sends each set bit of a word to the position its table entry names.
// Bits sent to the same position are ORed; targets outside the mask drop out.
// ----------------------------------------------------------------------------
module scs_permute (
   input  scs_pkg::bitmap_type     bits_in,
   input  scs_pkg::perm_table_type perm_table,
   input  scs_pkg::bitmap_type     size_mask,
   output scs_pkg::bitmap_type     bits_out
);

   scs_pkg::bitmap_type gathered;

   always_comb begin
      gathered = '0;
      for (int j = 0; j < scs_pkg::Positions; j++) begin
         for (int i = 0; i < scs_pkg::Positions; i++) begin
            if (bits_in[i] && (perm_table[i] == scs_pkg::IdxW'(j))) begin
               gathered[j] = 1'b1;
            end
         end
      end
   end

   assign bits_out = gathered & size_mask;

endmodule

// ----- src/scs_successor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Same-popcount successor
// Four-stage pipeline that forms the next bitmap with the same number of
// ones, counting from the top active position downward.
// ----------------------------------------------------------------------------
module scs_successor (
   input  logic                      clock,
   input  logic                      load,
   input  scs_pkg::bitmap_type       bitmap,
   input  scs_pkg::bitmap_type       size_mask,
   output scs_pkg::succ_result_type  result
);

   // Copies every set bit into all positions below it.
   function automatic scs_pkg::bitmap_type smear_down(input scs_pkg::bitmap_type v);
      scs_pkg::bitmap_type s;
      s = v;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | (s >> 16);
      return s;
   endfunction

   function automatic logic [scs_pkg::IdxW-1:0] encode(input scs_pkg::bitmap_type onehot);
      logic [scs_pkg::IdxW-1:0] idx;
      idx = '0;
      for (int i = 0; i < scs_pkg::Positions; i++) begin
         if (onehot[i]) begin
            idx = idx | scs_pkg::IdxW'(i);
         end
      end
      return idx;
   endfunction

   scs_pkg::bitmap_type      s1_bits_ff, s1_mask_ff;
   scs_pkg::bitmap_type      s2_rest_ff, s2_mask_ff;
   logic [scs_pkg::IdxW-1:0] s2_zero_pos_ff;
   scs_pkg::bitmap_type      s3_rest_ff, s3_fill_ff;
   logic [scs_pkg::IdxW-1:0] s3_top_ff;
   logic                     s3_exhausted_ff;
   scs_pkg::succ_result_type s4_result_ff;

   scs_pkg::bitmap_type      zero_smear, rest_smear, top_bit;
   logic [scs_pkg::IdxW-1:0] shift_up;

   // The run of ones at the top ends just above the highest zero in range.
   assign zero_smear = smear_down(~s1_bits_ff & s1_mask_ff);
   assign rest_smear = smear_down(s2_rest_ff);
   assign top_bit    = rest_smear & ~(rest_smear >> 1);
   assign shift_up   = s3_top_ff + scs_pkg::IdxW'(1);

   always_ff @(posedge clock) begin
      if (load) begin
         s1_bits_ff <= bitmap;
         s1_mask_ff <= size_mask;
      end
      s2_rest_ff     <= s1_bits_ff & zero_smear;
      s2_mask_ff     <= s1_mask_ff;
      s2_zero_pos_ff <= encode(zero_smear & ~(zero_smear >> 1));

      // The top run plus one more bit moves to just above the highest
      // remaining one, which is cleared.
      s3_rest_ff      <= s2_rest_ff & ~top_bit;
      s3_top_ff       <= encode(top_bit);
      s3_fill_ff      <= s2_mask_ff >> s2_zero_pos_ff;
      s3_exhausted_ff <= (s2_rest_ff == '0);

      s4_result_ff.exhausted   <= s3_exhausted_ff;
      s4_result_ff.next_bitmap <= s3_exhausted_ff ? '0
                                  : (s3_rest_ff | (s3_fill_ff << shift_up));
   end

   assign result = s4_result_ff;

endmodule

// ----- src/symmetry_canonical_subset_check_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry canonical subset check core
// Checks a bitmap against its seven images under the order-8 symmetry
// group and forms its same-popcount successor.
// Load word: strobe in the cycle after acceptance; one load a cycle when idle.
// Check word: busy while its passes run, one crossbar pass per cycle
// through the shared permutation unit; after the last pass the result
// strobe follows in the next cycle, and no new word is taken while busy.
// Reset sets active_size to 24; tables hold nothing until loaded.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module symmetry_canonical_subset_check_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [scs_pkg::IdxW-1:0]            req_table_index,
   input  logic [scs_pkg::IdxW-1:0]            req_reflect_target,
   input  logic [scs_pkg::IdxW-1:0]            req_transpose_target,
   input  scs_pkg::bitmap_type                 req_bitmap,
   output logic                                rsp_strobe,
   output logic                                rsp_is_canonical,
   output scs_pkg::bitmap_type                 rsp_next_bitmap,
   output logic                                rsp_exhausted,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam logic StIdle = 1'b0;
   localparam logic StRun  = 1'b1;

   // Lowest differing position holds a one in a: a ranks above b.
   function automatic logic ranks_above(input scs_pkg::bitmap_type a,
                                        input scs_pkg::bitmap_type b);
      scs_pkg::bitmap_type d;
      d = a ^ b;
      return |(a & d & (~d + scs_pkg::Positions'(1)));
   endfunction

   logic                           state_ff, state_in;
   logic [scs_pkg::StepW-1:0]      step_ff, step_in;
   logic [scs_pkg::SizeW-1:0]      active_size_ff;
   scs_pkg::perm_table_type        reflect_table_ff, transpose_table_ff;
   scs_pkg::bitmap_type            word_ff, word_in;
   scs_pkg::bitmap_type            operand_ff, operand_in;
   scs_pkg::bitmap_type            reflection_ff, reflection_in;
   logic                           canon_ff, canon_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic                           rsp_canon_ff, rsp_canon_in;
   scs_pkg::bitmap_type            rsp_next_ff, rsp_next_in;
   logic                           rsp_exh_ff, rsp_exh_in;

   logic                           accept, csr_write, image_smaller;
   logic [scs_pkg::SizeW-1:0]      eff_size;
   scs_pkg::bitmap_type            size_mask, masked_bitmap, image;
   scs_pkg::perm_table_type        pass_table;
   scs_pkg::succ_result_type       succ;

   assign accept    = start && (state_ff == StIdle);
   assign busy      = (state_ff == StRun);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr == scs_pkg::RegActiveSize)
                      ? {{(32 - scs_pkg::SizeW){1'b0}}, active_size_ff} : '0;

   always_comb begin
      priority if (active_size_ff == '0) begin
         eff_size = scs_pkg::SizeW'(1);
      end else if (active_size_ff > scs_pkg::SizeW'(scs_pkg::Positions)) begin
         eff_size = scs_pkg::SizeW'(scs_pkg::Positions);
      end else begin
         eff_size = active_size_ff;
      end
   end

   assign size_mask     = ~({scs_pkg::Positions{1'b1}} << eff_size);
   assign masked_bitmap = req_bitmap & size_mask;

   // Odd passes transpose, even passes reflect and are compared.
   assign pass_table = step_ff[0] ? transpose_table_ff : reflect_table_ff;

   scs_permute u_permute (
      .bits_in    (operand_ff),
      .perm_table (pass_table),
      .size_mask  (size_mask),
      .bits_out   (image)
   );

   scs_successor u_successor (
      .clock     (clock),
      .load      (accept && (req_operation == scs_pkg::OpCheck)),
      .bitmap    (masked_bitmap),
      .size_mask (size_mask),
      .result    (succ)
   );

   assign image_smaller = ranks_above(word_ff, image);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      word_in       = word_ff;
      operand_in    = operand_ff;
      reflection_in = reflection_ff;
      canon_in      = canon_ff;
      rsp_strobe_in = 1'b0;
      rsp_canon_in  = rsp_canon_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_exh_in    = rsp_exh_ff;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req_operation == scs_pkg::OpCheck) begin
                  state_in   = StRun;
                  step_in    = '0;
                  word_in    = masked_bitmap;
                  operand_in = masked_bitmap;
                  canon_in   = 1'b1;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_canon_in  = 1'b0;
                  rsp_next_in   = '0;
                  rsp_exh_in    = 1'b0;
               end
            end
         end
         StRun: begin
            if (!step_ff[0] && image_smaller) begin
               canon_in = 1'b0;
            end
            // The first pass forms the reflection, which later seeds the
            // second rotation chain.
            priority if (step_ff == '0) begin
               reflection_in = image;
            end else if (step_ff == scs_pkg::StepW'(scs_pkg::ChainPasses)) begin
               operand_in = reflection_ff;
            end else begin
               operand_in = image;
            end
            if (step_ff == scs_pkg::StepW'(scs_pkg::LastStep)) begin
               state_in      = StIdle;
               rsp_strobe_in = 1'b1;
               rsp_canon_in  = canon_ff && !image_smaller;
               rsp_next_in   = succ.next_bitmap;
               rsp_exh_in    = succ.exhausted;
            end else begin
               step_in = step_ff + scs_pkg::StepW'(1);
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StIdle;
         step_ff        <= '0;
         active_size_ff <= scs_pkg::SizeW'(scs_pkg::Positions);
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write && (paddr == scs_pkg::RegActiveSize)) begin
            active_size_ff <= pwdata[scs_pkg::SizeW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      operand_ff    <= operand_in;
      reflection_ff <= reflection_in;
      canon_ff      <= canon_in;
      rsp_canon_ff  <= rsp_canon_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_exh_ff    <= rsp_exh_in;
      if (accept && (req_operation == scs_pkg::OpLoad)
          && (req_table_index < scs_pkg::IdxW'(scs_pkg::Positions))) begin
         reflect_table_ff[req_table_index]   <= req_reflect_target;
         transpose_table_ff[req_table_index] <= req_transpose_target;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_is_canonical = rsp_canon_ff;
   assign rsp_next_bitmap  = rsp_next_ff;
   assign rsp_exhausted    = rsp_exh_ff;

   // The last crossbar pass ends the check and raises the strobe.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == StRun && step_ff == scs_pkg::StepW'(scs_pkg::LastStep))
      |=> (rsp_strobe_ff && state_ff == StIdle))
      else $error("check did not finish after its last pass");

   // A check word keeps the block busy; a load word does not.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == scs_pkg::OpCheck) |=> (busy && step_ff == '0))
      else $error("accepted check did not start the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      busy |-> (step_ff <= scs_pkg::StepW'(scs_pkg::LastStep)))
      else $error("step counter ran past the last pass");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_exh_ff) |-> (rsp_next_ff == '0))
      else $error("exhausted result carries a nonzero bitmap");

endmodule

// ----- tb/scs_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry canonical subset check: result checker
// Watches the command, result and register ports of the core, keeps its own
// copy of the index tables and the active size, predicts the result word of
// every accepted command word and compares it with the words that come out.
// ----------------------------------------------------------------------------
module scs_result_checker
   import scs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic             req_operation,
   input  logic [IdxW-1:0]  req_table_index,
   input  logic [IdxW-1:0]  req_reflect_target,
   input  logic [IdxW-1:0]  req_transpose_target,
   input  bitmap_type       req_bitmap,
   input  logic             rsp_strobe,
   input  logic             rsp_is_canonical,
   input  bitmap_type       rsp_next_bitmap,
   input  logic             rsp_exhausted,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int unsigned      mismatch_count,
   output int unsigned      pending
);

   localparam logic [2:0] SizeAddr = 3'(RegActiveSize * 4);

   typedef struct packed {
      logic            is_canonical;
      succ_result_type succ;
   } outcome_type;

   perm_table_type   reflect_map = '0;
   perm_table_type   transpose_map = '0;
   logic [SizeW-1:0] size_reg = SizeW'(Positions);
   outcome_type      outcome_q[$];
   int unsigned      fail_total = 0;

   function automatic int used_positions(logic [SizeW-1:0] s);
      if (s == 0) return 1;
      if (s > Positions) return Positions;
      return int'(s);
   endfunction

   // Targets at or above the active size fall off; duplicate targets merge.
   function automatic bitmap_type map_positions(bitmap_type m, perm_table_type tab, int n);
      bitmap_type img;
      img = '0;
      for (int i = 0; i < n; i++)
         if (m[i] && int'(tab[i]) < n) img[tab[i]] = 1'b1;
      return img;
   endfunction

   // True when a holds the 1 at the lowest position where a and b differ.
   function automatic logic outranks(bitmap_type a, bitmap_type b);
      bitmap_type diff, lowest;
      diff = a ^ b;
      lowest = diff & (~diff + 1'b1);
      return |(a & lowest);
   endfunction

   function automatic succ_result_type next_same_weight(bitmap_type m, int n);
      succ_result_type res;
      bitmap_type      rest;
      int              run, top;
      rest = m;
      run = 0;
      while (run < n && rest[n-1-run]) begin
         rest[n-1-run] = 1'b0;
         run++;
      end
      res.exhausted = (rest == '0);
      res.next_bitmap = '0;
      if (rest == '0) return res;
      top = 0;
      for (int i = 0; i < n; i++)
         if (rest[i]) top = i;
      rest[top] = 1'b0;
      for (int j = 0; j <= run; j++)
         if (top + 1 + j < n) rest[top+1+j] = 1'b1;
      res.next_bitmap = rest;
      return res;
   endfunction

   function automatic outcome_type predict_check(bitmap_type raw, int n,
                                                 perm_table_type refl_tab,
                                                 perm_table_type trans_tab);
      outcome_type res;
      bitmap_type  m, mirror, chain_a, chain_b;
      m = raw;
      for (int i = n; i < Positions; i++) m[i] = 1'b0;
      mirror = map_positions(m, refl_tab, n);
      res.is_canonical = !outranks(m, mirror);
      chain_a = m;
      chain_b = mirror;
      for (int r = 0; r < Rotations; r++) begin
         chain_a = map_positions(map_positions(chain_a, trans_tab, n), refl_tab, n);
         chain_b = map_positions(map_positions(chain_b, trans_tab, n), refl_tab, n);
         if (outranks(m, chain_a) || outranks(m, chain_b)) res.is_canonical = 1'b0;
      end
      res.succ = next_same_weight(m, used_positions(SizeW'(n)));
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         size_reg = SizeW'(Positions);
         outcome_q.delete();
      end else begin
         if (rsp_strobe) begin
            got.is_canonical = rsp_is_canonical;
            got.succ.next_bitmap = rsp_next_bitmap;
            got.succ.exhausted = rsp_exhausted;
            if (outcome_q.size() == 0) begin
               if (fail_total < 10)
                  $display({"%0t: result word with nothing expected: ",
                            "canonical %0b next %06h exhausted %0b"},
                           $realtime, got.is_canonical, got.succ.next_bitmap,
                           got.succ.exhausted);
               fail_total++;
            end else begin
               want = outcome_q.pop_front();
               if (got.is_canonical !== want.is_canonical ||
                   got.succ.next_bitmap !== want.succ.next_bitmap ||
                   got.succ.exhausted !== want.succ.exhausted) begin
                  if (fail_total < 10)
                     $display({"%0t: result mismatch: expected canonical %0b ",
                               "next %06h exhausted %0b, got canonical %0b ",
                               "next %06h exhausted %0b"},
                              $realtime, want.is_canonical, want.succ.next_bitmap,
                              want.succ.exhausted, got.is_canonical,
                              got.succ.next_bitmap, got.succ.exhausted);
                  fail_total++;
               end
            end
         end
         if (start && !busy) begin
            if (req_operation == OpLoad) begin
               if (req_table_index < Positions) begin
                  reflect_map[req_table_index] = req_reflect_target;
                  transpose_map[req_table_index] = req_transpose_target;
               end
               want = '0;
            end else begin
               want = predict_check(req_bitmap, used_positions(size_reg),
                                    reflect_map, transpose_map);
            end
            outcome_q.insert(outcome_q.size(), want);
         end
         if (psel && penable && pwrite && pready && paddr == SizeAddr)
            size_reg = pwdata[SizeW-1:0];
      end
      mismatch_count <= fail_total;
      pending <= outcome_q.size();
   end

endmodule

// ----- tb/tb_symmetry_canonical_subset_check_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symmetry canonical subset check core testbench
// Loads reflection and transposition tables, checks bitmaps under several
// active sizes (square grid symmetries, random permutations and arbitrary
// maps), with random sender gaps; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_symmetry_canonical_subset_check_core;
   import scs_pkg::*;

   localparam int         ClockPeriod = 10;
   localparam int         PhaseCount  = 12;
   localparam int         ChecksPerPhase = 60;
   localparam logic [2:0] SizeAddr = 3'(RegActiveSize * 4);

   typedef enum int {MapGrid, MapPerm, MapAny} map_style_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_operation;
   logic [IdxW-1:0]   req_table_index;
   logic [IdxW-1:0]   req_reflect_target;
   logic [IdxW-1:0]   req_transpose_target;
   bitmap_type        req_bitmap;
   logic              rsp_strobe;
   logic              rsp_is_canonical;
   bitmap_type        rsp_next_bitmap;
   logic              rsp_exhausted;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int unsigned       mismatch_count;
   int unsigned       pending;
   int                idle_pct = 0;

   int            phase_size[PhaseCount] = '{16, 24, 1, 9, 0, 4, 31, 16, 25, 0, 9, 24};
   map_style_type phase_style[PhaseCount] = '{MapGrid, MapPerm, MapAny, MapGrid,
                                              MapAny, MapGrid, MapAny, MapGrid,
                                              MapPerm, MapAny, MapGrid, MapPerm};

   symmetry_canonical_subset_check_core uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_table_index      (req_table_index),
      .req_reflect_target   (req_reflect_target),
      .req_transpose_target (req_transpose_target),
      .req_bitmap           (req_bitmap),
      .rsp_strobe           (rsp_strobe),
      .rsp_is_canonical     (rsp_is_canonical),
      .rsp_next_bitmap      (rsp_next_bitmap),
      .rsp_exhausted        (rsp_exhausted),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   scs_result_checker outcome_check (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_table_index      (req_table_index),
      .req_reflect_target   (req_reflect_target),
      .req_transpose_target (req_transpose_target),
      .req_bitmap           (req_bitmap),
      .rsp_strobe           (rsp_strobe),
      .rsp_is_canonical     (rsp_is_canonical),
      .rsp_next_bitmap      (rsp_next_bitmap),
      .rsp_exhausted        (rsp_exhausted),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .pready               (pready),
      .mismatch_count       (mismatch_count),
      .pending              (pending)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   initial begin
      #(ClockPeriod * 400000);
      $display("tb_symmetry_canonical_subset_check_core failed");
      $finish;
   end

   // Holds the word on the ports until the core takes it. Start stays high
   // afterwards so that back-to-back words need no second assignment.
   task automatic send_word(logic op, int idx, int refl_to, int trans_to, bitmap_type bm);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_table_index <= IdxW'(idx);
      req_reflect_target <= IdxW'(refl_to);
      req_transpose_target <= IdxW'(trans_to);
      req_bitmap <= bm;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic load_entry(int idx, int refl_to, int trans_to);
      send_word(OpLoad, idx, refl_to, trans_to, bitmap_type'($urandom));
   endtask

   task automatic check_word(bitmap_type bm);
      send_word(OpCheck, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), bm);
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_size(int value);
      wait_all_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SizeAddr;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic load_tables(map_style_type style, int n);
      int side, pick, tmp;
      int refl_to[Positions];
      int trans_to[Positions];
      side = 1;
      while ((side + 1) * (side + 1) <= n) side++;
      for (int i = 0; i < Positions; i++) begin
         refl_to[i] = i;
         trans_to[i] = i;
      end
      for (int i = n - 1; i > 0; i--) begin
         pick = $urandom_range(0, i);
         tmp = refl_to[i];
         refl_to[i] = refl_to[pick];
         refl_to[pick] = tmp;
         pick = $urandom_range(0, i);
         tmp = trans_to[i];
         trans_to[i] = trans_to[pick];
         trans_to[pick] = tmp;
      end
      for (int i = 0; i < n; i++) begin
         case (style)
            MapGrid: begin
               // Row r, column c: mirror the column, swap row and column.
               load_entry(i, (i / side) * side + side - 1 - i % side,
                          (i % side) * side + i / side);
            end
            MapPerm: begin
               load_entry(i, refl_to[i], trans_to[i]);
            end
            default: begin
               load_entry(i,
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, n - 1),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, n - 1));
            end
         endcase
      end
   endtask

   function automatic bitmap_type pick_bitmap(int n);
      bitmap_type bm;
      int         run;
      bm = '0;
      run = $urandom_range(1, n);
      case ($urandom_range(0, 4))
         0: begin
            bm = bitmap_type'($urandom);
         end
         1: begin
            repeat ($urandom_range(1, 3)) bm[$urandom_range(0, n - 1)] = 1'b1;
         end
         2: begin
            // Top run of ones: exhausts the successor if no lower bit is set.
            for (int i = n - run; i < n; i++) bm[i] = 1'b1;
            if ($urandom_range(0, 1)) bm[$urandom_range(0, n - 1)] = 1'b1;
         end
         3: begin
            for (int i = 0; i < run; i++) bm[i] = 1'b1;
         end
         default: begin
            for (int i = 0; i < n; i++) bm[i] = 1'($urandom_range(0, 1));
         end
      endcase
      if ($urandom_range(0, 3) == 0)
         for (int i = n; i < Positions; i++) bm[i] = 1'($urandom_range(0, 1));
      return bm;
   endfunction

   initial begin
      int size_val, used, spins;
      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= OpLoad;
      req_table_index <= '0;
      req_reflect_target <= '0;
      req_transpose_target <= '0;
      req_bitmap <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every entry gets written before the first check.
      for (int i = 0; i < Positions; i++) load_entry(i, Positions - 1 - i, (i + 7) % Positions);
      load_entry(31, 31, 31);
      load_entry(24, 0, 0);
      check_word(24'h000000);
      check_word(24'hFFFFFF);
      check_word(24'h000001);
      check_word(24'h800000);
      check_word(24'hFFF000);
      check_word(24'h000FFF);
      check_word(24'hAAAAAA);
      check_word(24'h555555);
      // Out-of-range targets drop the bit; a shared target merges two bits.
      load_entry(5, 31, 24);
      check_word(24'h000020);
      check_word(24'hFFFFFF);
      load_entry(3, 0, 0);
      check_word(24'h800008);
      set_size(1);
      check_word(24'h000001);
      check_word(24'hFFFFFF);
      set_size(0);
      check_word(24'h000001);
      set_size(31);
      check_word(24'hFFFFFF);

      for (int p = 0; p < PhaseCount; p++) begin
         size_val = phase_size[p];
         if (p == 9) size_val = $urandom_range(1, Positions);
         used = (size_val == 0) ? 1 : (size_val > Positions) ? Positions : size_val;
         idle_pct = (p < 4) ? 11 : (p < 8) ? 67 : 0;
         set_size(size_val);
         load_tables(phase_style[p], used);
         for (int k = 0; k < ChecksPerPhase; k++) begin
            if ($urandom_range(0, 24) == 0)
               load_entry($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
            else
               check_word(pick_bitmap(used));
         end
      end

      start <= 1'b0;
      @(posedge clock);
      spins = 0;
      while (pending != 0 && spins < 1000) begin
         @(posedge clock);
         spins++;
      end
      repeat (20) @(posedge clock);
      if (pending != 0)
         $display("%0d expected result words never arrived", pending);
      if (mismatch_count == 0 && pending == 0) begin
         $display("tb_symmetry_canonical_subset_check_core passed");
      end else begin
         $display("tb_symmetry_canonical_subset_check_core failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/scs_pkg.sv
src/scs_permute.sv
src/scs_successor.sv
src/symmetry_canonical_subset_check_core.sv
tb/scs_result_checker.sv
tb/tb_symmetry_canonical_subset_check_core.sv
